// ===== rtl/bcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_pkg: shared types and constants of the balance control tick
// Field layout of the stream buses, microcode control word, datapath
// status and the fixed-point constants of the cascaded loops.
// ----------------------------------------------------------------------------
package bcp_pkg;

  // field widths
  localparam int SPD_W   = 16;
  localparam int ANG_W   = 17;
  localparam int RATE_W  = 16;
  localparam int STEER_W = 11;
  localparam int DRV_W   = 16;
  localparam int GAIN_W  = 32;
  localparam int FILT_W  = 18;
  localparam int INTEG_W = 15;
  localparam int TA_W    = 24;

  // datapath widths
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = GAIN_W + MUL_B_W;
  localparam int ACC_W   = 60;
  localparam int BASE_W  = 36;
  localparam int LIM_W   = 38;
  localparam int DIV_N_W = 21;

  // stream payload layout, lowest bit first
  localparam int S_TDATA_W   = 96;
  localparam int M_TDATA_W   = 32;
  localparam int IN_TGT_LSB  = 0;
  localparam int IN_LSP_LSB  = IN_TGT_LSB + SPD_W;
  localparam int IN_RSP_LSB  = IN_LSP_LSB + SPD_W;
  localparam int IN_ANG_LSB  = IN_RSP_LSB + SPD_W;
  localparam int IN_RATE_LSB = IN_ANG_LSB + ANG_W;
  localparam int IN_STR_LSB  = IN_RATE_LSB + RATE_W;

  // configuration registers
  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;
  localparam logic signed [GAIN_W-1:0] GAIN_RESET [NUM_REGS] = '{
    -32'sd17695, -32'sd66, 32'sd19660800, -32'sd327680,
    32'sd52429, -32'sd4587520, -32'sd9830
  };

  // loop constants
  localparam int INTEG_LIM   = 10000;
  localparam int CUTOFF_Q88  = 7680;
  localparam int CLEAR_Q88   = 10240;
  localparam int ANGLE_MAX   = 8388607;
  localparam int ANGLE_MIN   = -8388608;
  localparam int DRV_MAX     = 32767;
  localparam int DRV_MIN     = -32768;
  localparam int TA_SHIFT    = 8;
  localparam int UP_SHIFT    = 24;
  localparam int VEL_SHIFT   = 16;
  localparam int TURN_SHIFT  = 16;
  // divide by ten: floor(n * 1677722 / 2^24) is exact for n < 2^22
  localparam int DIV10_SHIFT = 24;
  localparam logic signed [GAIN_W-1:0] DIV10_RECIP = 32'sd1677722;

  // microcode
  localparam int PC_W = 5;

  typedef enum logic [2:0] {
    MA_SPD_P  = 3'd0,
    MA_SPD_I  = 3'd1,
    MA_UP_P   = 3'd2,
    MA_UP_D   = 3'd3,
    MA_TURN_P = 3'd4,
    MA_DRV_P  = 3'd5,
    MA_DRV_I  = 3'd6,
    MA_RECIP  = 3'd7
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_DIVMAG,
    MB_SF,
    MB_SI,
    MB_DF,
    MB_DI,
    MB_RATE,
    MB_ANGERR,
    MB_STEER
  } mul_b_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_E1,
    ACC_SF_NUM,
    ACC_E2,
    ACC_DF_NUM,
    ACC_LOADP,
    ACC_ADDP,
    ACC_ADDP8
  } acc_op_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_SF,
    WB_SI_INT,
    WB_SI_CLR,
    WB_DF,
    WB_DI_INT,
    WB_DI_CLR,
    WB_TA,
    WB_UP,
    WB_VEL,
    WB_OUT
  } wb_op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_TGT_NZ,
    JMP_NOT_BIG,
    JMP_END
  } jmp_t;

  typedef struct packed {
    logic            mul_en;
    mul_a_t          mul_a;
    mul_b_t          mul_b;
    acc_op_t         acc_op;
    wb_op_t          wb;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  localparam ctrl_word_t CW_NOP = '{
    mul_en: 1'b0, mul_a: MA_RECIP, mul_b: MB_DIVMAG, acc_op: ACC_HOLD,
    wb: WB_NONE, jmp: JMP_NONE, target: '0
  };

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    logic en;    // execute the current control word
    logic load;  // capture a new input transaction
  } dp_ctl_t;

  typedef struct packed {
    logic tgt_nz;   // target speed is nonzero
    logic not_big;  // tilt within +-40 degrees
  } dp_status_t;

endpackage

// ===== rtl/bcp_ucode_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_ucode_rom: microprogram of one control tick
// One control word per step; the sequencer walks it and takes the jumps.
// ----------------------------------------------------------------------------
module bcp_ucode_rom (
  input  logic [bcp_pkg::PC_W-1:0] pc,
  output bcp_pkg::ctrl_word_t      cw
);

  localparam logic [bcp_pkg::PC_W-1:0] STEP_DF_DIV = 5'd7;
  localparam logic [bcp_pkg::PC_W-1:0] STEP_UP_WB  = 5'd17;

  always_comb begin
    cw = bcp_pkg::CW_NOP;
    case (pc)
      5'd0: begin                       // e1 = mean speed - target
        cw.acc_op = bcp_pkg::ACC_E1;
      end
      5'd1: begin                       // 2*e1 + 8*sf
        cw.acc_op = bcp_pkg::ACC_SF_NUM;
      end
      5'd2: begin                       // /10 via reciprocal
        cw.mul_en = 1'b1;
        cw.mul_a  = bcp_pkg::MA_RECIP;
        cw.mul_b  = bcp_pkg::MB_DIVMAG;
      end
      5'd3: begin
        cw.wb = bcp_pkg::WB_SF;
      end
      5'd4: begin
        cw.wb     = bcp_pkg::WB_SI_INT;
        cw.acc_op = bcp_pkg::ACC_E2;
      end
      5'd5: begin                       // 3*e2 + 7*df, skip clear if target moving
        cw.acc_op = bcp_pkg::ACC_DF_NUM;
        cw.jmp    = bcp_pkg::JMP_TGT_NZ;
        cw.target = STEP_DF_DIV;
      end
      5'd6: begin
        cw.wb = bcp_pkg::WB_SI_CLR;
      end
      5'd7: begin
        cw.mul_en = 1'b1;
        cw.mul_a  = bcp_pkg::MA_RECIP;
        cw.mul_b  = bcp_pkg::MB_DIVMAG;
      end
      5'd8: begin
        cw.wb     = bcp_pkg::WB_DF;
        cw.mul_en = 1'b1;
        cw.mul_a  = bcp_pkg::MA_SPD_P;
        cw.mul_b  = bcp_pkg::MB_SF;
      end
      5'd9: begin
        cw.mul_en = 1'b1;
        cw.mul_a  = bcp_pkg::MA_SPD_I;
        cw.mul_b  = bcp_pkg::MB_SI;
        cw.acc_op = bcp_pkg::ACC_LOADP;
      end
      5'd10: begin
        cw.wb     = bcp_pkg::WB_DI_INT;
        cw.acc_op = bcp_pkg::ACC_ADDP;
      end
      5'd11: begin
        cw.wb     = bcp_pkg::WB_TA;
        cw.mul_en = 1'b1;
        cw.mul_a  = bcp_pkg::MA_DRV_P;
        cw.mul_b  = bcp_pkg::MB_DF;
      end
      5'd12: begin
        cw.mul_en = 1'b1;
        cw.mul_a  = bcp_pkg::MA_DRV_I;
        cw.mul_b  = bcp_pkg::MB_DI;
        cw.acc_op = bcp_pkg::ACC_LOADP;
      end
      5'd13: begin
        cw.acc_op = bcp_pkg::ACC_ADDP;
        cw.mul_en = 1'b1;
        cw.mul_a  = bcp_pkg::MA_UP_P;
        cw.mul_b  = bcp_pkg::MB_ANGERR;
      end
      5'd14: begin
        cw.wb     = bcp_pkg::WB_VEL;
        cw.mul_en = 1'b1;
        cw.mul_a  = bcp_pkg::MA_UP_D;
        cw.mul_b  = bcp_pkg::MB_RATE;
        cw.acc_op = bcp_pkg::ACC_LOADP;
      end
      5'd15: begin                      // keep drive integral unless tilt is large
        cw.acc_op = bcp_pkg::ACC_ADDP8;
        cw.mul_en = 1'b1;
        cw.mul_a  = bcp_pkg::MA_TURN_P;
        cw.mul_b  = bcp_pkg::MB_STEER;
        cw.jmp    = bcp_pkg::JMP_NOT_BIG;
        cw.target = STEP_UP_WB;
      end
      5'd16: begin
        cw.wb = bcp_pkg::WB_DI_CLR;
      end
      5'd17: begin
        cw.wb     = bcp_pkg::WB_UP;
        cw.acc_op = bcp_pkg::ACC_LOADP;
      end
      5'd18: begin
        cw.wb  = bcp_pkg::WB_OUT;
        cw.jmp = bcp_pkg::JMP_END;
      end
      default: begin
        cw.jmp = bcp_pkg::JMP_END;
      end
    endcase
  end

endmodule

// ===== rtl/bcp_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_sequencer: step counter, jumps and stream handshakes
// Runs the microprogram once per input transaction and owns output valid.
// ----------------------------------------------------------------------------
module bcp_sequencer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  input  bcp_pkg::ctrl_word_t      cw,
  input  bcp_pkg::dp_status_t      status,
  output logic [bcp_pkg::PC_W-1:0] pc,
  output bcp_pkg::dp_ctl_t         ctl
);

  bcp_pkg::seq_state_t        state, state_next;
  logic [bcp_pkg::PC_W-1:0]   pc_next;
  logic                       out_valid, out_valid_next;
  logic                       last, stall, accept, step_en, take;
  logic [bcp_pkg::PC_W-1:0]   pc_inc;

  assign s_tready = (state == bcp_pkg::SEQ_IDLE);
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bcp_pkg::SEQ_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    last    = (cw.jmp == bcp_pkg::JMP_END);
    // final step waits while the previous result is still unclaimed
    stall   = last && out_valid && !m_tready;
    accept  = (state == bcp_pkg::SEQ_IDLE) && s_tvalid;
    step_en = (state == bcp_pkg::SEQ_RUN) && !stall;
    pc_inc  = pc + bcp_pkg::PC_W'(1);

    case (cw.jmp)
      bcp_pkg::JMP_TGT_NZ:  take = status.tgt_nz;
      bcp_pkg::JMP_NOT_BIG: take = status.not_big;
      default:              take = 1'b0;
    endcase

    state_next = state;
    pc_next    = pc;
    case (state)
      bcp_pkg::SEQ_IDLE: begin
        if (accept) begin
          state_next = bcp_pkg::SEQ_RUN;
          pc_next    = '0;
        end
      end
      bcp_pkg::SEQ_RUN: begin
        if (step_en) begin
          if (last) begin
            state_next = bcp_pkg::SEQ_IDLE;
            pc_next    = '0;
          end else if (take) begin
            pc_next = cw.target;
          end else begin
            pc_next = pc_inc;
          end
        end
      end
      default: begin
        state_next = bcp_pkg::SEQ_IDLE;
        pc_next    = '0;
      end
    endcase

    if (step_en && last) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end

    ctl.en   = step_en;
    ctl.load = accept;
  end

endmodule

// ===== rtl/bcp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_datapath: shared multiplier, accumulator and loop state
// Gains, input latch, filter/integral state and the output register.
// ----------------------------------------------------------------------------
module bcp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  bcp_pkg::ctrl_word_t                 cw,
  input  bcp_pkg::dp_ctl_t                    ctl,
  input  logic [bcp_pkg::S_TDATA_W-1:0]       in_data,
  input  logic                                cfg_we,
  input  logic [bcp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bcp_pkg::GAIN_W-1:0]          cfg_data,
  output bcp_pkg::dp_status_t                 status,
  output logic [bcp_pkg::M_TDATA_W-1:0]       out_data,
  output logic                                out_cut
);

  localparam int ACC_W   = bcp_pkg::ACC_W;
  localparam int FILT_W  = bcp_pkg::FILT_W;
  localparam int INTEG_W = bcp_pkg::INTEG_W;
  localparam int SPD_W   = bcp_pkg::SPD_W;
  localparam int ANG_W   = bcp_pkg::ANG_W;
  localparam int LIM_W   = bcp_pkg::LIM_W;
  localparam int DRV_W   = bcp_pkg::DRV_W;
  localparam int MUL_B_W = bcp_pkg::MUL_B_W;
  localparam int PROD_W  = bcp_pkg::PROD_W;

  localparam logic signed [ANG_W-1:0] CUT_POS = ANG_W'(bcp_pkg::CUTOFF_Q88);
  localparam logic signed [ANG_W-1:0] CUT_NEG = ANG_W'(-bcp_pkg::CUTOFF_Q88);
  localparam logic signed [ANG_W-1:0] BIG_POS = ANG_W'(bcp_pkg::CLEAR_Q88);
  localparam logic signed [ANG_W-1:0] BIG_NEG = ANG_W'(-bcp_pkg::CLEAR_Q88);

  // signed shift right rounding toward zero
  function automatic logic signed [ACC_W-1:0] trunc_shr(
    input logic signed [ACC_W-1:0] x,
    input logic [5:0]              sh
  );
    logic signed [ACC_W-1:0] bias;
    bias = x[ACC_W-1] ? ((ACC_W'(1) <<< sh) - ACC_W'(1)) : '0;
    return (x + bias) >>> sh;
  endfunction

  function automatic logic signed [INTEG_W-1:0] clamp_integ(
    input logic signed [FILT_W:0] x
  );
    if (x > (FILT_W+1)'(bcp_pkg::INTEG_LIM)) begin
      return INTEG_W'(bcp_pkg::INTEG_LIM);
    end else if (x < (FILT_W+1)'(-bcp_pkg::INTEG_LIM)) begin
      return INTEG_W'(-bcp_pkg::INTEG_LIM);
    end
    return INTEG_W'(x);
  endfunction

  function automatic logic signed [DRV_W-1:0] sat_drive(
    input logic signed [LIM_W-1:0] x
  );
    if (x > LIM_W'(bcp_pkg::DRV_MAX)) begin
      return DRV_W'(bcp_pkg::DRV_MAX);
    end else if (x < LIM_W'(bcp_pkg::DRV_MIN)) begin
      return DRV_W'(bcp_pkg::DRV_MIN);
    end
    return DRV_W'(x);
  endfunction

  // latched transaction
  logic signed [SPD_W-1:0]             tgt, lsp, rsp;
  logic signed [ANG_W-1:0]             ang;
  logic signed [bcp_pkg::RATE_W-1:0]   rate;
  logic signed [bcp_pkg::STEER_W-1:0]  steer;

  logic signed [bcp_pkg::GAIN_W-1:0]   gain [bcp_pkg::NUM_REGS];

  // loop state
  logic signed [FILT_W-1:0]            sf, df;
  logic signed [INTEG_W-1:0]           si, di;
  logic signed [bcp_pkg::TA_W-1:0]     ta;
  logic signed [bcp_pkg::BASE_W-1:0]   up, vel;

  logic signed [ACC_W-1:0]             acc, acc_next;
  logic signed [PROD_W-1:0]            prod;

  logic signed [bcp_pkg::GAIN_W-1:0]   a_op;
  logic signed [MUL_B_W-1:0]           b_op;
  logic signed [SPD_W:0]               wsum, whalf;
  logic signed [ACC_W-1:0]             acc_mag, sf_ext, df_ext, p_ext;
  logic [FILT_W-1:0]                   quo;
  logic signed [FILT_W:0]              quo_s;
  logic signed [FILT_W:0]              si_sum, di_sum;
  logic signed [ACC_W-1:0]             ta_raw, up_raw, vel_raw, turn_raw;
  logic signed [bcp_pkg::TA_W-1:0]     ta_sat;
  logic signed [LIM_W-1:0]             base, turn;
  logic signed [DRV_W-1:0]             ld_sat, rd_sat;
  logic                                cut;

  always_comb begin
    status.tgt_nz  = (tgt != '0);
    status.not_big = !((ang > BIG_POS) || (ang < BIG_NEG));
    cut            = (ang > CUT_POS) || (ang < CUT_NEG);

    case (cw.mul_a)
      bcp_pkg::MA_SPD_P:  a_op = gain[0];
      bcp_pkg::MA_SPD_I:  a_op = gain[1];
      bcp_pkg::MA_UP_P:   a_op = gain[2];
      bcp_pkg::MA_UP_D:   a_op = gain[3];
      bcp_pkg::MA_TURN_P: a_op = gain[4];
      bcp_pkg::MA_DRV_P:  a_op = gain[5];
      bcp_pkg::MA_DRV_I:  a_op = gain[6];
      default:            a_op = bcp_pkg::DIV10_RECIP;
    endcase

    acc_mag = acc[ACC_W-1] ? -acc : acc;
    case (cw.mul_b)
      bcp_pkg::MB_DIVMAG: b_op = MUL_B_W'({1'b0, acc_mag[bcp_pkg::DIV_N_W-1:0]});
      bcp_pkg::MB_SF:     b_op = MUL_B_W'(sf);
      bcp_pkg::MB_SI:     b_op = MUL_B_W'(si);
      bcp_pkg::MB_DF:     b_op = MUL_B_W'(df);
      bcp_pkg::MB_DI:     b_op = MUL_B_W'(di);
      bcp_pkg::MB_RATE:   b_op = MUL_B_W'(rate);
      bcp_pkg::MB_ANGERR: b_op = MUL_B_W'(ang) - MUL_B_W'(ta);
      default:            b_op = MUL_B_W'(steer);
    endcase

    // wheel mean, halved toward zero
    wsum   = (SPD_W+1)'(lsp) + (SPD_W+1)'(rsp);
    whalf  = (wsum + $signed({{SPD_W{1'b0}}, wsum[SPD_W]})) >>> 1;
    sf_ext = ACC_W'(sf);
    df_ext = ACC_W'(df);
    p_ext  = ACC_W'(prod);

    case (cw.acc_op)
      bcp_pkg::ACC_E1:     acc_next = ACC_W'(whalf) - ACC_W'(tgt);
      bcp_pkg::ACC_SF_NUM: acc_next = (acc <<< 1) + (sf_ext <<< 3);
      bcp_pkg::ACC_E2:     acc_next = ACC_W'(lsp) + ACC_W'(rsp) - ACC_W'(tgt);
      bcp_pkg::ACC_DF_NUM: acc_next = acc + (acc <<< 1) + (df_ext <<< 3) - df_ext;
      bcp_pkg::ACC_LOADP:  acc_next = p_ext;
      bcp_pkg::ACC_ADDP:   acc_next = acc + p_ext;
      bcp_pkg::ACC_ADDP8:  acc_next = acc + (p_ext <<< 8);
      default:             acc_next = acc;
    endcase

    // quotient of |numerator| / 10, sign restored from the numerator
    quo   = prod[bcp_pkg::DIV10_SHIFT +: FILT_W];
    quo_s = acc[ACC_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    si_sum = (FILT_W+1)'(si) + (FILT_W+1)'(sf);
    di_sum = (FILT_W+1)'(di) + (FILT_W+1)'(df);

    ta_raw   = trunc_shr(acc, 6'(bcp_pkg::TA_SHIFT));
    up_raw   = trunc_shr(acc, 6'(bcp_pkg::UP_SHIFT));
    vel_raw  = trunc_shr(acc, 6'(bcp_pkg::VEL_SHIFT));
    turn_raw = trunc_shr(acc, 6'(bcp_pkg::TURN_SHIFT));

    if (ta_raw > ACC_W'(bcp_pkg::ANGLE_MAX)) begin
      ta_sat = bcp_pkg::TA_W'(bcp_pkg::ANGLE_MAX);
    end else if (ta_raw < ACC_W'(bcp_pkg::ANGLE_MIN)) begin
      ta_sat = bcp_pkg::TA_W'(bcp_pkg::ANGLE_MIN);
    end else begin
      ta_sat = bcp_pkg::TA_W'(ta_raw);
    end

    turn   = LIM_W'(turn_raw);
    base   = LIM_W'(up) - LIM_W'(vel);
    ld_sat = sat_drive(base + turn);
    rd_sat = sat_drive(base - turn);
  end

  // configuration and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < bcp_pkg::NUM_REGS; k++) begin
        gain[k] <= bcp_pkg::GAIN_RESET[k];
      end
      sf <= '0;
      si <= '0;
      df <= '0;
      di <= '0;
    end else begin
      if (cfg_we && (cfg_index < bcp_pkg::CFG_IDX_W'(bcp_pkg::NUM_REGS))) begin
        gain[cfg_index] <= cfg_data;
      end
      if (ctl.en) begin
        case (cw.wb)
          bcp_pkg::WB_SF:     sf <= FILT_W'(quo_s);
          bcp_pkg::WB_SI_INT: si <= clamp_integ(si_sum);
          bcp_pkg::WB_SI_CLR: si <= '0;
          bcp_pkg::WB_DF:     df <= FILT_W'(quo_s);
          bcp_pkg::WB_DI_INT: di <= clamp_integ(di_sum);
          bcp_pkg::WB_DI_CLR: di <= '0;
          default: ;
        endcase
      end
    end
  end

  // payload latch, accumulator, product, ta/up/vel and output registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tgt   <= $signed(in_data[bcp_pkg::IN_TGT_LSB  +: SPD_W]);
      lsp   <= $signed(in_data[bcp_pkg::IN_LSP_LSB  +: SPD_W]);
      rsp   <= $signed(in_data[bcp_pkg::IN_RSP_LSB  +: SPD_W]);
      ang   <= $signed(in_data[bcp_pkg::IN_ANG_LSB  +: ANG_W]);
      rate  <= $signed(in_data[bcp_pkg::IN_RATE_LSB +: bcp_pkg::RATE_W]);
      steer <= $signed(in_data[bcp_pkg::IN_STR_LSB  +: bcp_pkg::STEER_W]);
    end
    if (ctl.en) begin
      acc <= acc_next;
      if (cw.mul_en) begin
        prod <= PROD_W'(a_op) * PROD_W'(b_op);
      end
      case (cw.wb)
        bcp_pkg::WB_TA:  ta  <= ta_sat;
        bcp_pkg::WB_UP:  up  <= bcp_pkg::BASE_W'(up_raw);
        bcp_pkg::WB_VEL: vel <= bcp_pkg::BASE_W'(vel_raw);
        bcp_pkg::WB_OUT: begin
          out_cut  <= cut;
          out_data <= cut ? '0 : {rd_sat, ld_sat};
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/balance_cascade_pid_tick.sv =====
`timescale 1ns / 1ps
// Each input transaction runs the microprogram at one microcode step a cycle, except that the
//   final step waits while a prior result is unclaimed; the integral-clear steps run only when
//   target speed is zero or tilt exceeds 40 degrees. A new tick is taken only after the last one
//   ends, as the single shared 32x26 multiplier is walked by the microprogram.
// Reset (rst, synchronous, active high): gains return to defaults, filter and integral
//   state clear to zero, no result pending, input ready.
// ----------------------------------------------------------------------------
// balance_cascade_pid_tick: cascaded PI/PD control tick of a balancing robot
// Microcoded sequencer over one multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module balance_cascade_pid_tick (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // target_speed[15:0], left_speed[31:16], right_speed[47:32],
  // tilt_angle[64:48], tilt_rate[80:65], steer_command[91:81], zero fill
  input  logic [bcp_pkg::S_TDATA_W-1:0]     s_tdata,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // left_drive[15:0], right_drive[31:16]
  output logic [bcp_pkg::M_TDATA_W-1:0]     m_tdata,
  // tilt_cutoff
  output logic                              m_tuser,
  // gain register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bcp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcp_pkg::GAIN_W-1:0]        cfg_data
);

  logic [bcp_pkg::PC_W-1:0] pc;
  bcp_pkg::ctrl_word_t      cw;
  bcp_pkg::dp_ctl_t         ctl;
  bcp_pkg::dp_status_t      status;

  // Gain writes are taken in any cycle; the user must issue them only while idle, as the block does not enforce it.
  assign cfg_ready = 1'b1;

  // Program store: step counter in, control word out.
  bcp_ucode_rom u_rom (
    .pc (pc),
    .cw (cw)
  );

  // Step counter, conditional jumps and both stream handshakes. The input
  // side opens again as soon as a tick finishes, while its result can still
  // sit in the output register waiting for m_tready.
  bcp_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cw       (cw),
    .status   (status),
    .pc       (pc),
    .ctl      (ctl)
  );

  // Shared multiplier (registered product), accumulator with the filter
  // numerators, divide-by-ten through a reciprocal multiply, truncating
  // shifts and the clamps. Loop state and gains live here too.
  bcp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cw        (cw),
    .ctl       (ctl),
    .in_data   (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_data  (m_tdata),
    .out_cut   (m_tuser)
  );

endmodule

// ===== rtl/bcp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_checker: port-level checks of the balance control tick
// Attached to the top level with a bind statement below.
// ----------------------------------------------------------------------------
module bcp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [bcp_pkg::M_TDATA_W-1:0]     m_tdata,
  input logic                              m_tuser
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // cutoff forces both drives to zero
  a_cut_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("drives nonzero under tilt cutoff");

  // one tick at a time: input closes after a transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while busy");

  // no result the cycle right after a transaction with nothing pending
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared too early");

  // reset leaves the block idle and empty
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

endmodule

bind balance_cascade_pid_tick bcp_checker u_bcp_checker (.*);
